@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds in a cycle, consequent sequence starts in the same cycle.
`define AFFG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("affine grid assertion failed");
// Antecedent holds in a cycle, consequent holds in the next one.
`define AFFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("affine grid assertion failed");
`else
`define AFFG_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define AFFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/affg_pkg.sv @@
// ----------------------------------------------------------------------------
// Affine grid package
// Request and result types, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package affg_pkg;

    // Widths fixed by the register and field formats.
    localparam int SIZE_W    = 11;  // grid size registers
    localparam int IDX_W     = 10;  // row and column index
    localparam int DIV_K     = 28;  // reciprocal scale 2^DIV_K
    localparam int QUO_W     = 28;  // reciprocal and quotient width
    localparam int DEN2_W    = 12;  // twice the denominator
    localparam int COORD_W   = 29;  // normalized coordinate, signed Q13.16
    localparam int THETA_W   = 32;
    localparam int PROD_W    = 61;  // theta times coordinate, Q29.32
    localparam int ACC_W     = 62;  // sum of two products
    localparam int RND_W     = 46;  // sum rounded to Q30.16
    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        CFG_GRID_HEIGHT = 2'd0,
        CFG_GRID_WIDTH  = 2'd1,
        CFG_CORNER_MODE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic        [IDX_W-1:0]   row_index;
        logic        [IDX_W-1:0]   col_index;
        logic signed [THETA_W-1:0] theta_xx;
        logic signed [THETA_W-1:0] theta_xy;
        logic signed [THETA_W-1:0] theta_xt;
        logic signed [THETA_W-1:0] theta_yx;
        logic signed [THETA_W-1:0] theta_yy;
        logic signed [THETA_W-1:0] theta_yt;
    } request_t;

    typedef struct packed {
        logic signed [THETA_W-1:0] grid_x;
        logic signed [THETA_W-1:0] grid_y;
    } result_t;

endpackage

@@ sv/affine_grid_coordinate_generator.sv @@
// ----------------------------------------------------------------------------
// Affine grid coordinate generator
// Maps a pixel row and column into [-1,1] and applies a 2x3 affine matrix.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high and busy is low,
// so a new pixel can enter in every cycle. Its result is on result with done
// high for exactly one cycle once it has passed the coordinate pipeline; the
// receiver cannot stall, and the pipeline never holds results back.
// The normalization divides by the grid size, which is done with a stored
// reciprocal per axis. Those reciprocals come from a shared one-bit-per-cycle
// divider that runs after reset and after every configuration write, and busy
// stays high while it runs.
// Configuration writes are always accepted (cfg_ready is tied high) and are
// expected only while no request is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_grid_coordinate_generator #(
    parameter int MAX_GRID_SIZE = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           start,
    output logic                           busy,
    input  affg_pkg::request_t             request,
    // Result channel
    output logic                           done,
    output affg_pkg::result_t              result,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [affg_pkg::SIZE_W-1:0]    cfg_data
);

    localparam int SW = affg_pkg::SIZE_W;
    localparam int QW = affg_pkg::QUO_W;
    localparam int DW = affg_pkg::DEN2_W;
    localparam int CW = affg_pkg::COORD_W;
    localparam int PW = affg_pkg::PROD_W;
    localparam int AW = affg_pkg::ACC_W;
    localparam int RW = affg_pkg::RND_W;
    localparam int TW = affg_pkg::THETA_W;
    localparam int LATENCY = 7;
    // The size registers are SW bits wide, so a limit above their range never bites.
    localparam logic [SW-1:0] MAX_SIZE =
        (MAX_GRID_SIZE > (2**SW - 1)) ? {SW{1'b1}} : SW'(MAX_GRID_SIZE);
    localparam logic [4:0] DIV_FIRST = 5'(affg_pkg::DIV_K);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    // Front end of one axis: magnitude numerator scaled for rounding, and sign.
    typedef struct packed {
        logic [QW-1:0] n;
        logic          neg;
    } axis_front_t;

    typedef struct packed {
        logic [QW-1:0] n;
        logic [QW-1:0] q;
        logic          neg;
    } axis_quot_t;

    typedef struct packed {
        logic [QW-1:0]   n;
        logic [QW-1:0]   q;
        logic [QW+DW-1:0] qd;
        logic            neg;
    } axis_check_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0] height_reg;
    logic [SW-1:0] width_reg;
    logic          align_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= SW'(16);
            width_reg  <= SW'(16);
            align_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                affg_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_data;
                affg_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_data;
                affg_pkg::CFG_CORNER_MODE: align_reg  <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Effective sizes: zero counts as one, and the size limit caps the rest.
    // With corner alignment the denominator is n-1, otherwise n. A single
    // pixel with corner alignment has no denominator and maps to -1 directly.
    logic [SW-1:0] n_w, n_h, den_w, den_h;
    logic [DW-1:0] d2_w, d2_h;
    logic          deg_w, deg_h;

    always_comb
    begin
        n_w = (width_reg == '0) ? SW'(1) :
              ((width_reg > MAX_SIZE) ? MAX_SIZE : width_reg);
        n_h = (height_reg == '0) ? SW'(1) :
              ((height_reg > MAX_SIZE) ? MAX_SIZE : height_reg);
        den_w = align_reg ? (n_w - SW'(1)) : n_w;
        den_h = align_reg ? (n_h - SW'(1)) : n_h;
        d2_w  = {den_w, 1'b0};
        d2_h  = {den_h, 1'b0};
        deg_w = align_reg && (n_w == SW'(1));
        deg_h = align_reg && (n_h == SW'(1));
    end

    // ------------------------------------------------------------------
    // Reciprocal divider: floor(2^DIV_K / (2*den)) for each axis, one
    // quotient bit per cycle, width axis first, then height.
    // ------------------------------------------------------------------
    div_state_t      div_state_reg, div_state_next;
    logic            div_axis_reg, div_axis_next;
    logic [4:0]      div_cnt_reg, div_cnt_next;
    logic [DW-1:0]   div_rem_reg, div_rem_next;
    logic [QW-1:0]   div_quo_reg, div_quo_next;
    logic [QW-1:0]   recip_w_reg, recip_w_next;
    logic [QW-1:0]   recip_h_reg, recip_h_next;
    logic [DW-1:0]   div_divisor;
    logic [DW:0]     div_shift;
    logic            div_ge;

    always_comb
    begin
        div_state_next = div_state_reg;
        div_axis_next  = div_axis_reg;
        div_cnt_next   = div_cnt_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        recip_w_next   = recip_w_reg;
        recip_h_next   = recip_h_reg;
        div_divisor    = div_axis_reg ? d2_h : d2_w;
        // The dividend is a single one at bit DIV_K.
        div_shift      = {div_rem_reg, (div_cnt_reg == DIV_FIRST)};
        div_ge         = (div_shift >= {1'b0, div_divisor});

        unique case (div_state_reg)
            DIV_IDLE:
            begin
            end
            DIV_RUN:
            begin
                div_rem_next = div_ge ? DW'(div_shift - {1'b0, div_divisor})
                                      : div_shift[DW-1:0];
                div_quo_next = {div_quo_reg[QW-2:0], div_ge};
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0)
                begin
                    div_cnt_next = DIV_FIRST;
                    div_rem_next = '0;
                    if (div_axis_reg)
                    begin
                        recip_h_next   = {div_quo_reg[QW-2:0], div_ge};
                        div_state_next = DIV_IDLE;
                    end
                    else
                    begin
                        recip_w_next  = {div_quo_reg[QW-2:0], div_ge};
                        div_axis_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Any configuration write starts the reciprocals over.
        if (cfg_valid && cfg_ready)
        begin
            div_state_next = DIV_RUN;
            div_axis_next  = 1'b0;
            div_cnt_next   = DIV_FIRST;
            div_rem_next   = '0;
            div_quo_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_RUN;
            div_axis_reg  <= 1'b0;
            div_cnt_reg   <= DIV_FIRST;
            div_rem_reg   <= '0;
            div_quo_reg   <= '0;
            recip_w_reg   <= '0;
            recip_h_reg   <= '0;
        end
        else
        begin
            div_state_reg <= div_state_next;
            div_axis_reg  <= div_axis_next;
            div_cnt_reg   <= div_cnt_next;
            div_rem_reg   <= div_rem_next;
            div_quo_reg   <= div_quo_next;
            recip_w_reg   <= recip_w_next;
            recip_h_reg   <= recip_h_next;
        end
    end

    assign busy = (div_state_reg == DIV_RUN);

    // ------------------------------------------------------------------
    // Coordinate pipeline
    // Stage 1: signed numerator 2*i+1-n, folded to magnitude and scaled so
    //          that n / (2*den) is the round-half-away quotient.
    // Stage 2: quotient estimate from the reciprocal (low by at most one).
    // Stage 3: estimate times divisor.
    // Stage 4: one-step correction, sign, single-pixel case -> u and v.
    // Stage 5: the four matrix products in Q29.32.
    // Stage 6: pair sums rounded to Q30.16, ties toward +infinity.
    // Stage 7: translation added and saturated into the output register.
    // ------------------------------------------------------------------
    function automatic axis_front_t front(input logic [affg_pkg::IDX_W-1:0] idx,
                                          input logic [SW-1:0] n,
                                          input logic [SW-1:0] den);
        logic signed [SW+1:0] num;
        logic        [SW-1:0] mag;
        axis_front_t          f;
        num   = $signed({2'b00, idx, 1'b1}) - $signed({2'b00, n});
        mag   = num[SW+1] ? SW'(-num) : SW'(num);
        f.n   = {mag, {(QW-SW){1'b0}}} + QW'(den);
        f.neg = num[SW+1];
        return f;
    endfunction

    logic [LATENCY-1:0] pipe_valid_reg;
    logic               accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
        end
        else
        begin
            pipe_valid_reg <= {pipe_valid_reg[LATENCY-2:0], accept};
        end
    end

    affg_pkg::request_t req_s1_reg, req_s2_reg, req_s3_reg, req_s4_reg;
    affg_pkg::request_t req_s5_reg, req_s6_reg;
    axis_front_t        fu_s1_reg, fv_s1_reg;
    axis_quot_t         qu_s2_reg, qv_s2_reg;
    axis_check_t        cu_s3_reg, cv_s3_reg;
    logic signed [CW-1:0] u_s4_reg, v_s4_reg, u_s4_next, v_s4_next;
    logic signed [PW-1:0] pxx_s5_reg, pxy_s5_reg, pyx_s5_reg, pyy_s5_reg;
    logic signed [RW-1:0] rx_s6_reg, ry_s6_reg, rx_s6_next, ry_s6_next;
    affg_pkg::result_t    result_reg, result_next;
    logic [2*QW-1:0]      pu_prod, pv_prod;
    logic [QW+DW-1:0]     ru, rv;
    logic [QW-1:0]        qfix_u, qfix_v;
    logic signed [AW-1:0] acc_x, acc_y;
    logic signed [RW:0]   tot_x, tot_y;

    function automatic logic signed [TW-1:0] sat32(input logic signed [RW:0] v);
        logic signed [TW-1:0] r;
        if (v[RW:TW-1] == {(RW-TW+2){v[RW]}})
            r = v[TW-1:0];
        else
            r = v[RW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [CW-1:0] coord(input logic [QW-1:0] q,
                                                   input logic neg,
                                                   input logic deg);
        logic signed [CW-1:0] c;
        c = $signed({1'b0, q});
        if (deg)
            c = -$signed(CW'(1 << affg_pkg::FRAC_BITS));
        else if (neg)
            c = -c;
        return c;
    endfunction

    always_comb
    begin
        pu_prod = fu_s1_reg.n * recip_w_reg;
        pv_prod = fv_s1_reg.n * recip_h_reg;

        ru = {{DW{1'b0}}, cu_s3_reg.n} - cu_s3_reg.qd;
        rv = {{DW{1'b0}}, cv_s3_reg.n} - cv_s3_reg.qd;
        qfix_u = (ru >= (QW+DW)'(d2_w)) ? (cu_s3_reg.q + QW'(1)) : cu_s3_reg.q;
        qfix_v = (rv >= (QW+DW)'(d2_h)) ? (cv_s3_reg.q + QW'(1)) : cv_s3_reg.q;
        u_s4_next = coord(qfix_u, cu_s3_reg.neg, deg_w);
        v_s4_next = coord(qfix_v, cv_s3_reg.neg, deg_h);

        acc_x = AW'(pxx_s5_reg) + AW'(pxy_s5_reg);
        acc_y = AW'(pyx_s5_reg) + AW'(pyy_s5_reg);
        rx_s6_next = RW'((acc_x + AW'(1 << (affg_pkg::FRAC_BITS - 1)))
                         >>> affg_pkg::FRAC_BITS);
        ry_s6_next = RW'((acc_y + AW'(1 << (affg_pkg::FRAC_BITS - 1)))
                         >>> affg_pkg::FRAC_BITS);

        tot_x = (RW+1)'(rx_s6_reg) + (RW+1)'(req_s6_reg.theta_xt);
        tot_y = (RW+1)'(ry_s6_reg) + (RW+1)'(req_s6_reg.theta_yt);
        result_next.grid_x = sat32(tot_x);
        result_next.grid_y = sat32(tot_y);
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        req_s1_reg <= request;
        fu_s1_reg  <= front(request.col_index, n_w, den_w);
        fv_s1_reg  <= front(request.row_index, n_h, den_h);

        req_s2_reg   <= req_s1_reg;
        qu_s2_reg.n  <= fu_s1_reg.n;
        qu_s2_reg.q  <= pu_prod[2*QW-1:QW];
        qu_s2_reg.neg <= fu_s1_reg.neg;
        qv_s2_reg.n  <= fv_s1_reg.n;
        qv_s2_reg.q  <= pv_prod[2*QW-1:QW];
        qv_s2_reg.neg <= fv_s1_reg.neg;

        req_s3_reg    <= req_s2_reg;
        cu_s3_reg.n   <= qu_s2_reg.n;
        cu_s3_reg.q   <= qu_s2_reg.q;
        cu_s3_reg.qd  <= qu_s2_reg.q * d2_w;
        cu_s3_reg.neg <= qu_s2_reg.neg;
        cv_s3_reg.n   <= qv_s2_reg.n;
        cv_s3_reg.q   <= qv_s2_reg.q;
        cv_s3_reg.qd  <= qv_s2_reg.q * d2_h;
        cv_s3_reg.neg <= qv_s2_reg.neg;

        req_s4_reg <= req_s3_reg;
        u_s4_reg   <= u_s4_next;
        v_s4_reg   <= v_s4_next;

        req_s5_reg <= req_s4_reg;
        pxx_s5_reg <= req_s4_reg.theta_xx * u_s4_reg;
        pxy_s5_reg <= req_s4_reg.theta_xy * v_s4_reg;
        pyx_s5_reg <= req_s4_reg.theta_yx * u_s4_reg;
        pyy_s5_reg <= req_s4_reg.theta_yy * v_s4_reg;

        req_s6_reg <= req_s5_reg;
        rx_s6_reg  <= rx_s6_next;
        ry_s6_reg  <= ry_s6_next;

        result_reg <= result_next;
    end

    assign done   = pipe_valid_reg[LATENCY-1];
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every accepted request later yields its result strobe.
    `AFFG_ASSERT_IMPL(a_result_follows, clk, rst_n, start && !busy, ##LATENCY done)
    // No result strobe appears without a matching earlier accepted request.
    `AFFG_ASSERT_IMPL(a_no_spurious, clk, rst_n, done, $past(start && !busy, LATENCY))
    // A configuration write always restarts the reciprocal computation.
    `AFFG_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_valid && cfg_ready, busy)

endmodule
